/* design/matrix_vector_multiply_assert.svh */
`ifndef MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// same-cycle implication, off during reset
`define MVM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mvm assertion failed");

// next-cycle implication, off during reset
`define MVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mvm assertion failed");

`endif

/* design/mvm_pkg.sv */
package mvm_pkg;

  localparam int ACC_W     = 48;
  localparam int ROW_W     = 12;
  localparam int REG_W     = 13;
  localparam int CFG_IDX_W = 8;

  localparam logic [REG_W-1:0] ROW_LIMIT  = 13'd4096;
  localparam logic [REG_W-1:0] COLS_RESET = 13'd4096;
  localparam logic [REG_W-1:0] ROWS_RESET = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 8'd1;

  typedef enum logic {
    MODE_VEC = 1'b0,
    MODE_MAT = 1'b1
  } mode_t;

  typedef struct packed {
    logic             is_mat;
    logic             row_end;
    logic             last_row;
    logic [ROW_W-1:0] row_idx;
  } ctl_t;

endpackage

/* design/mvm_front.sv */
`include "matrix_vector_multiply_assert.svh"

module mvm_front import mvm_pkg::*; #(
  parameter int MAX_COLS   = 4096,
  parameter int DATA_WIDTH = 16,
  parameter int AW         = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  input  logic                  in_mode,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic                  q_full,
  output logic                  push,
  output logic [AW-1:0]         push_addr,
  output logic [DATA_WIDTH-1:0] push_value,
  output ctl_t                  push_ctl
);

  localparam int CNTW = (AW + 1 > REG_W) ? AW + 1 : REG_W;

  logic [REG_W-1:0] num_cols_r, num_rows_r;
  logic [AW-1:0]    ptr_r, col_r;
  logic [ROW_W-1:0] row_r;

  logic [CNTW-1:0]  eff_cols, cols_ext, ptr_inc, col_inc;
  logic [REG_W-1:0] eff_rows, row_inc;
  logic [AW-1:0]    ptr_nxt, col_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic             row_end, last;

  always_comb begin
    cols_ext = CNTW'(num_cols_r);
    priority if (num_cols_r == '0) begin
      eff_cols = CNTW'(1);
    end else if (cols_ext > CNTW'(MAX_COLS)) begin
      eff_cols = CNTW'(MAX_COLS);
    end else begin
      eff_cols = cols_ext;
    end
    priority if (num_rows_r == '0) begin
      eff_rows = REG_W'(1);
    end else if (num_rows_r > ROW_LIMIT) begin
      eff_rows = ROW_LIMIT;
    end else begin
      eff_rows = num_rows_r;
    end
  end

  assign ptr_inc = CNTW'(ptr_r) + CNTW'(1);
  assign col_inc = CNTW'(col_r) + CNTW'(1);
  assign row_inc = {1'b0, row_r} + REG_W'(1);
  assign ptr_nxt = (ptr_inc >= eff_cols) ? '0 : ptr_inc[AW-1:0];
  assign row_end = (col_inc >= eff_cols);
  assign col_nxt = row_end ? '0 : col_inc[AW-1:0];
  assign last    = (row_inc >= eff_rows);
  assign row_nxt = last ? '0 : row_inc[ROW_W-1:0];

  assign push       = in_valid && !q_full;
  assign push_addr  = (in_mode == MODE_MAT) ? col_r : ptr_r;
  assign push_value = in_value;

  always_comb begin
    push_ctl.is_mat   = (in_mode == MODE_MAT);
    push_ctl.row_end  = row_end;
    push_ctl.last_row = last;
    push_ctl.row_idx  = row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= COLS_RESET;
      num_rows_r <= ROWS_RESET;
      ptr_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_NUM_COLS) num_cols_r <= cfg_data;
        if (cfg_index == CFG_NUM_ROWS) num_rows_r <= cfg_data;
      end
      if (push) begin
        if (in_mode == MODE_MAT) begin
          col_r <= col_nxt;
          if (row_end) row_r <= row_nxt;
        end else begin
          ptr_r <= ptr_nxt;
        end
      end
    end
  end

  `MVM_ASSERT_NEXT(a_col_wrap, push && push_ctl.is_mat && push_ctl.row_end, col_r == '0)
  `MVM_ASSERT_SAME(a_last_wraps_row, push && push_ctl.is_mat && push_ctl.row_end
    && push_ctl.last_row, row_nxt == '0)

endmodule

/* design/mvm_queue.sv */
`include "matrix_vector_multiply_assert.svh"

module mvm_queue #(
  parameter int W     = 32,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         nonempty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign dout     = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      priority if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  `MVM_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `MVM_ASSERT_SAME(a_no_pop_empty, pop, nonempty)

endmodule

/* design/mvm_back.sv */
`include "matrix_vector_multiply_assert.svh"

module mvm_back import mvm_pkg::*; #(
  parameter int MAX_COLS   = 4096,
  parameter int DATA_WIDTH = 16,
  parameter int AW         = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  ctl_t                  q_ctl,
  input  logic [AW-1:0]         q_addr,
  input  logic [DATA_WIDTH-1:0] q_value,
  output logic                  pop,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [ACC_W-1:0]      out_sum,
  output logic [ROW_W-1:0]      out_idx,
  output logic                  out_last
);

  localparam int PW = 2 * DATA_WIDTH;

  logic [DATA_WIDTH-1:0] vec_mem [MAX_COLS];

  logic                  s1_v_r, s2_v_r, out_v_r;
  ctl_t                  s1_ctl_r, s2_ctl_r;
  logic [DATA_WIDTH-1:0] s1_value_r, s1_rdata_r;
  logic signed [PW-1:0]  prod_r;
  logic [ACC_W-1:0]      acc_r, prod_ext, acc_sum;
  logic [ACC_W-1:0]      sum_r;
  logic [ROW_W-1:0]      idx_r;
  logic                  last_r;
  logic                  adv;

  assign adv = !out_v_r || out_ready;
  assign pop = q_valid && adv;

  always_ff @(posedge clk) begin
    if (pop) begin
      if (!q_ctl.is_mat) vec_mem[q_addr] <= q_value;
      s1_rdata_r <= vec_mem[q_addr];
    end
  end

  generate
    if (PW >= ACC_W) begin : g_trunc
      assign prod_ext = prod_r[ACC_W-1:0];
    end else begin : g_sext
      assign prod_ext = {{(ACC_W - PW){prod_r[PW-1]}}, prod_r};
    end
  endgenerate

  assign acc_sum = acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r   <= q_ctl;
      s1_value_r <= q_value;
      s2_ctl_r   <= s1_ctl_r;
      prod_r     <= $signed(s1_value_r) * $signed(s1_rdata_r);
      if (s2_v_r && s2_ctl_r.is_mat && s2_ctl_r.row_end) begin
        sum_r  <= acc_sum;
        idx_r  <= s2_ctl_r.row_idx;
        last_r <= s2_ctl_r.last_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      acc_r   <= '0;
    end else if (adv) begin
      s1_v_r  <= pop;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r && s2_ctl_r.is_mat && s2_ctl_r.row_end;
      if (s2_v_r && s2_ctl_r.is_mat) begin
        acc_r <= s2_ctl_r.row_end ? '0 : acc_sum;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_sum   = sum_r;
  assign out_idx   = idx_r;
  assign out_last  = last_r;

  `MVM_ASSERT_NEXT(a_acc_clear, adv && s2_v_r && s2_ctl_r.is_mat && s2_ctl_r.row_end,
    acc_r == '0)
  `MVM_ASSERT_NEXT(a_stall_freeze, !adv, s2_v_r == $past(s2_v_r) && acc_r == $past(acc_r))

endmodule

/* design/matrix_vector_multiply.sv */
// Matrix-vector product in signed Q4.12, exact 48-bit row sums.
// Input channel in_*: tuser is the mode (0 loads the next vector element,
// 1 supplies the next matrix element, row-major); tdata holds the value.
// Load the vector first; the load index wraps at num_cols.
// Result channel out_*: one item per completed row; tdata holds row_sum
// (Q24.24) and row_index, tlast marks the final row of the matrix.
// Config channel cfg_*: index 0 is num_cols, index 1 is num_rows; write
// only while idle. cfg_ready is always high.
// Throughput: one item per cycle unless a low out_tready stalls the pipeline,
// set by the single pipelined multiply and the acc_r accumulate loop. A row's
// result passes the queue, s1, s2 and the output register to out_tvalid.
// A four-entry queue separates the address/counter front from the memory,
// multiply and accumulate pipeline. While a result waits on a low
// out_tready the pipeline holds, the queue fills, and in_tready falls once
// it is full.
// Reset clears counters, accumulator and pipeline and sets both counts to
// 4096. The vector store is not cleared; load it before any matrix item.
module matrix_vector_multiply import mvm_pkg::*; #(
  parameter int MAX_COLS   = 4096,
  parameter int DATA_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [REG_W-1:0]                      cfg_data,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // value
  input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] in_tdata,
  // mode
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // row_sum, row_index
  output logic [((ACC_W + ROW_W + 7) / 8) * 8-1:0] out_tdata,
  output logic                                  out_tlast
);

  localparam int AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int OUT_W = ((ACC_W + ROW_W + 7) / 8) * 8;
  localparam int QW    = $bits(ctl_t) + AW + DATA_WIDTH;

  logic                  push, q_full, q_valid, pop;
  logic [AW-1:0]         push_addr;
  logic [DATA_WIDTH-1:0] push_value;
  ctl_t                  push_ctl;
  logic [QW-1:0]         q_dout;
  logic [ACC_W-1:0]      sum;
  logic [ROW_W-1:0]      idx;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;

  mvm_front #(.MAX_COLS(MAX_COLS), .DATA_WIDTH(DATA_WIDTH), .AW(AW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_tvalid),
    .in_mode    (in_tuser),
    .in_value   (in_tdata[DATA_WIDTH-1:0]),
    .q_full     (q_full),
    .push       (push),
    .push_addr  (push_addr),
    .push_value (push_value),
    .push_ctl   (push_ctl)
  );

  mvm_queue #(.W(QW), .DEPTH(4)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .din      ({push_ctl, push_addr, push_value}),
    .full     (q_full),
    .pop      (pop),
    .dout     (q_dout),
    .nonempty (q_valid)
  );

  mvm_back #(.MAX_COLS(MAX_COLS), .DATA_WIDTH(DATA_WIDTH), .AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ctl     (q_dout[QW-1 -: $bits(ctl_t)]),
    .q_addr    (q_dout[DATA_WIDTH +: AW]),
    .q_value   (q_dout[DATA_WIDTH-1:0]),
    .pop       (pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_sum   (sum),
    .out_idx   (idx),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{(OUT_W - ACC_W - ROW_W){1'b0}}, idx, sum};

endmodule

/* test/matrix_vector_multiply_tb.sv */
module matrix_vector_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mvm_pkg::*;

  localparam int MAX_COLS     = 4096;
  localparam int DATA_W       = 16;
  localparam int IN_W         = ((DATA_W + 7) / 8) * 8;
  localparam int OUT_W        = ((ACC_W + ROW_W + 7) / 8) * 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 40000;
  localparam int RANDOM_ITEMS = 350;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd200;

  typedef struct {
    logic [ACC_W-1:0] sum;
    logic [ROW_W-1:0] idx;
    logic             last;
  } row_result_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]  cfg_data   = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;  // value
  logic              in_tuser   = 1'b0;  // mode
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;  // row_sum, row_index
  logic              out_tlast;

  row_result_t       pending_rows[$];
  logic signed [DATA_W-1:0] vec_copy [MAX_COLS];
  bit                vec_loaded [MAX_COLS];
  int unsigned       load_ptr;
  int unsigned       col_ptr;
  int unsigned       row_ptr;
  logic [ACC_W-1:0]  row_acc;
  logic [REG_W-1:0]  cols_set;
  logic [REG_W-1:0]  rows_set;

  int  items_sent   = 0;
  int  rows_checked = 0;
  int  cfg_writes   = 0;
  int  errors       = 0;
  int  cycles       = 0;
  bit  gaps_on      = 1'b1;
  int  hold_req     = 0;
  int  rdy_gap      = 0;

  always #5 clk = ~clk;

  matrix_vector_multiply #(
    .MAX_COLS  (MAX_COLS),
    .DATA_WIDTH(DATA_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  function automatic int unsigned active_cols();
    if (cols_set == 0) return 1;
    if (cols_set > MAX_COLS) return MAX_COLS;
    return cols_set;
  endfunction

  function automatic int unsigned active_rows();
    if (rows_set == 0) return 1;
    if (rows_set > ROW_LIMIT) return ROW_LIMIT;
    return rows_set;
  endfunction

  function automatic void clear_dot_product();
    foreach (vec_loaded[i]) begin
      vec_loaded[i] = 1'b0;
      vec_copy[i]   = '0;
    end
    load_ptr = 0;
    col_ptr  = 0;
    row_ptr  = 0;
    row_acc  = '0;
    cols_set = COLS_RESET;
    rows_set = ROWS_RESET;
  endfunction

  function automatic void step_dot_product(mode_t m, logic [DATA_W-1:0] v);
    longint      prod;
    row_result_t r;
    if (m == MODE_VEC) begin
      if (load_ptr >= MAX_COLS) load_ptr = 0;
      vec_copy[load_ptr]   = v;
      vec_loaded[load_ptr] = 1'b1;
      load_ptr++;
      if (load_ptr >= active_cols()) load_ptr = 0;
      return;
    end
    if (col_ptr >= MAX_COLS) col_ptr = 0;
    prod    = longint'($signed(v)) * longint'(vec_copy[col_ptr]);
    row_acc = row_acc + prod[ACC_W-1:0];
    col_ptr++;
    if (col_ptr < active_cols()) return;
    r.sum  = row_acc;
    r.idx  = row_ptr[ROW_W-1:0];
    r.last = (row_ptr + 1 >= active_rows());
    pending_rows.push_back(r);
    row_ptr = r.last ? 0 : row_ptr + 1;
    col_ptr = 0;
    row_acc = '0;
  endfunction

  function automatic bit next_col_loaded();
    int unsigned c;
    c = (col_ptr >= MAX_COLS) ? 0 : col_ptr;
    return vec_loaded[c];
  endfunction

  function automatic logic [DATA_W-1:0] rnd_value();
    return DATA_W'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH at cycle %0d: %s", cycles, msg);
  endtask

  task automatic send_item(mode_t m, logic [DATA_W-1:0] v);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    step_dot_product(m, v);
    items_sent++;
  endtask

  task automatic load_vector(int n);
    repeat (n) send_item(MODE_VEC, rnd_value());
  endtask

  task automatic send_matrix(int n);
    repeat (n) begin
      if (next_col_loaded()) send_item(MODE_MAT, rnd_value());
      else send_item(MODE_VEC, rnd_value());
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_NUM_COLS) cols_set = val;
    else if (idx == CFG_NUM_ROWS) rows_set = val;
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic test_wide_rows();
    load_vector(24);
    send_matrix(20);
    wait_idle();
    write_reg(CFG_NUM_COLS, 13'd16);
    send_matrix(1 + 16);
    wait_idle();
    write_reg(CFG_NUM_COLS, 13'h1FFF);
    write_reg(CFG_NUM_ROWS, '0);
    send_matrix(18);
    wait_idle();
    write_reg(CFG_NUM_COLS, 13'd16);
    send_matrix(1 + 16);
    wait_idle();
  endtask

  task automatic test_many_rows();
    write_reg(CFG_NUM_COLS, 13'd1);
    write_reg(CFG_NUM_ROWS, 13'h1FFF);
    load_vector(1);
    send_matrix(30);
    wait_idle();
    write_reg(CFG_NUM_ROWS, 13'd20);
    send_matrix(1 + 20 + 2);
    wait_idle();
  endtask

  task automatic test_extremes();
    logic [DATA_W-1:0] vec_pat [4] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001};
    logic [DATA_W-1:0] mat_pat [16] = '{
      16'h8000, 16'h8000, 16'h8000, 16'h8000,
      16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
      16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001};
    write_reg(CFG_NUM_COLS, 13'd4);
    write_reg(CFG_NUM_ROWS, 13'd2);
    foreach (vec_pat[i]) send_item(MODE_VEC, vec_pat[i]);
    foreach (mat_pat[i]) send_item(MODE_MAT, mat_pat[i]);
    wait_idle();
  endtask

  task automatic test_count_edges();
    write_reg(CFG_NUM_COLS, '0);
    write_reg(CFG_NUM_ROWS, '0);
    load_vector(1);
    send_matrix(3);
    wait_idle();
    write_reg(CFG_UNUSED_IDX, 13'h1FFF);
    send_matrix(2);
    wait_idle();
  endtask

  task automatic test_shrink_mid_stream();
    write_reg(CFG_NUM_COLS, 13'd8);
    write_reg(CFG_NUM_ROWS, 13'd10);
    load_vector(8);
    load_vector(3);
    send_matrix(3 * 8 + 5);
    wait_idle();
    write_reg(CFG_NUM_COLS, 13'd3);
    write_reg(CFG_NUM_ROWS, 13'd2);
    load_vector(1);
    send_matrix(1 + 3);
    wait_idle();
  endtask

  task automatic test_backpressure();
    bit saved_gaps;
    write_reg(CFG_NUM_COLS, 13'd1);
    write_reg(CFG_NUM_ROWS, 13'd7);
    load_vector(1);
    saved_gaps = gaps_on;
    gaps_on    = 1'b0;
    hold_req   = 150;
    send_matrix(40);
    gaps_on    = saved_gaps;
    wait_idle();
  endtask

  task automatic test_random();
    int sent;
    int n;
    int unsigned ec;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent > RANDOM_ITEMS - 110) gaps_on = 1'b0;
      wait_idle();
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_NUM_COLS, '0);
        1:       write_reg(CFG_NUM_COLS, REG_W'($urandom_range(4097, 8191)));
        2:       write_reg(CFG_NUM_COLS, REG_W'($urandom_range(17, 64)));
        default: write_reg(CFG_NUM_COLS, REG_W'($urandom_range(1, 16)));
      endcase
      case ($urandom_range(0, 7))
        0:       write_reg(CFG_NUM_ROWS, '0);
        1:       write_reg(CFG_NUM_ROWS, REG_W'($urandom_range(4097, 8191)));
        2:       write_reg(CFG_UNUSED_IDX, REG_W'($urandom_range(0, 8191)));
        default: write_reg(CFG_NUM_ROWS, REG_W'($urandom_range(1, 8)));
      endcase
      ec = active_cols();
      if (ec > 64) ec = 64;
      load_vector(int'(ec));
      sent += int'(ec);
      n = $urandom_range(40, 80);
      repeat (n) begin
        if ($urandom_range(0, 9) < 8) send_matrix(1);
        else send_item(MODE_VEC, rnd_value());
      end
      sent += n;
    end
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      out_tready <= 1'b0;
      hold_req--;
    end else if (rdy_gap > 0) begin
      out_tready <= 1'b0;
      rdy_gap--;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      rdy_gap = $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    row_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected row result, row_index %0d",
                                  out_tdata[ACC_W +: ROW_W]));
      end else begin
        exp_r = pending_rows.pop_front();
        rows_checked++;
        if (out_tdata[ACC_W-1:0] !== exp_r.sum)
          report_mismatch($sformatf("row %0d: row_sum %h, expected %h", exp_r.idx,
                                    out_tdata[ACC_W-1:0], exp_r.sum));
        if (out_tdata[ACC_W +: ROW_W] !== exp_r.idx)
          report_mismatch($sformatf("row_index %0d, expected %0d",
                                    out_tdata[ACC_W +: ROW_W], exp_r.idx));
        if (out_tlast !== exp_r.last)
          report_mismatch($sformatf("row %0d: last_row %b, expected %b", exp_r.idx,
                                    out_tlast, exp_r.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_rows.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    clear_dot_product();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_wide_rows();
    test_many_rows();
    test_extremes();
    test_count_edges();
    test_shrink_mid_stream();
    test_backpressure();
    test_random();
    wait_idle();
    $display("Sent %0d items, checked %0d row sums, made %0d register writes",
             items_sent, rows_checked, cfg_writes);
    $display("Reset, zero and oversized counts, counts shrunk mid-row and mid-matrix, %s%0d",
             "extreme values, long output stall, random streams; mismatches: ", errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
